// ----- sv/baro_temp_press_compensation_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Shared property shapes used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESS_COMPENSATION_TOP_DEFINES_SVH
`define BARO_TEMP_PRESS_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BPTC_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BPTC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bptc_pkg.sv -----
// ----------------------------------------------------------------------------
// bptc_pkg
// Types and constants shared by the barometric compensation modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

    typedef enum logic [2:0] {
        REG_OSS  = 3'd0,
        REG_AC12 = 3'd1,
        REG_AC34 = 3'd2,
        REG_AC56 = 3'd3,
        REG_B12  = 3'd4,
        REG_MCMD = 3'd5
    } cfg_idx_t;

    // Calibration set as seen by the datapath; signed members are cast at use.
    typedef struct packed {
        logic [1:0]  oss;
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
    } cal_t;

    localparam int TDIV_DW = 27;
    localparam int TDIV_VW = 20;
    localparam int PDIV_DW = 32;
    localparam int PDIV_VW = 17;

    localparam logic [11:0] B6_OFFSET   = 12'd4000;
    localparam logic [11:0] P_SQ_COEF   = 12'd3038;
    localparam logic [12:0] P_LIN_COEF  = 13'd7357;
    localparam logic [11:0] P_OFFSET    = 12'd3791;
    localparam logic [15:0] B7_SCALE    = 16'd50000;
    localparam logic [31:0] HALF_OFFSET = 32'd32768;
    localparam logic [17:0] P_MAX       = 18'h3FFFF;

    typedef struct packed {
        logic [18:0] x1;
        logic [23:0] up;
        logic        qneg;
        logic        zero;
    } tdiv_tag_t;

    typedef struct packed {
        logic [15:0] temp;
        logic        err;
        logic        hi;
    } pdiv_tag_t;

endpackage

`default_nettype wire

// ----- sv/bptc_cfg.sv -----
// ----------------------------------------------------------------------------
// bptc_cfg
// Calibration and oversampling register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_wdata,
    output bptc_pkg::cal_t     cal
);
    import bptc_pkg::*;

    logic [1:0]  oss_reg;
    logic [31:0] ac12_reg;
    logic [31:0] ac34_reg;
    logic [31:0] ac56_reg;
    logic [31:0] b12_reg;
    logic [31:0] mcmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oss_reg  <= '0;
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_OSS:  oss_reg  <= cfg_wdata[1:0];
                REG_AC12: ac12_reg <= cfg_wdata;
                REG_AC34: ac34_reg <= cfg_wdata;
                REG_AC56: ac56_reg <= cfg_wdata;
                REG_B12:  b12_reg  <= cfg_wdata;
                REG_MCMD: mcmd_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cal.oss = oss_reg;
    assign cal.ac1 = ac12_reg[31:16];
    assign cal.ac2 = ac12_reg[15:0];
    assign cal.ac3 = ac34_reg[31:16];
    assign cal.ac4 = ac34_reg[15:0];
    assign cal.ac5 = ac56_reg[31:16];
    assign cal.ac6 = ac56_reg[15:0];
    assign cal.b1  = b12_reg[31:16];
    assign cal.b2  = b12_reg[15:0];
    assign cal.mc  = mcmd_reg[31:16];
    assign cal.md  = mcmd_reg[15:0];

endmodule

`default_nettype wire

// ----- sv/bptc_div.sv -----
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined restoring divider, one quotient bit per stage, with a tag path.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_div #(
    parameter int DW = 32,
    parameter int VW = 17,
    parameter int TW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_num,
    input  wire logic [VW-1:0] in_den,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [DW-1:0]      out_quo,
    output logic [TW-1:0]      out_tag
);

    logic [DW-1:0] vld_reg;
    logic [DW-1:0] num_reg [DW];
    logic [VW-1:0] rem_reg [DW];
    logic [VW-1:0] den_reg [DW];
    logic [TW-1:0] tag_reg [DW];

    genvar k;
    for (k = 0; k < DW; k++) begin : g_stage
        logic          cur_v;
        logic [DW-1:0] cur_n;
        logic [VW-1:0] cur_r;
        logic [VW-1:0] cur_d;
        logic [TW-1:0] cur_t;
        logic [VW:0]   trial;
        logic [VW:0]   diff;

        if (k == 0) begin : g_first
            assign cur_v = in_valid;
            assign cur_n = in_num;
            assign cur_r = '0;
            assign cur_d = in_den;
            assign cur_t = in_tag;
        end else begin : g_rest
            assign cur_v = vld_reg[k-1];
            assign cur_n = num_reg[k-1];
            assign cur_r = rem_reg[k-1];
            assign cur_d = den_reg[k-1];
            assign cur_t = tag_reg[k-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor.
        assign trial = {cur_r, cur_n[DW-1]};
        assign diff  = trial - {1'b0, cur_d};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= {cur_n[DW-2:0], ~diff[VW]};
                rem_reg[k] <= diff[VW] ? trial[VW-1:0] : diff[VW-1:0];
                den_reg[k] <= cur_d;
                tag_reg[k] <= cur_t;
            end
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign out_quo   = num_reg[DW-1];
    assign out_tag   = tag_reg[DW-1];

endmodule

`default_nettype wire

// ----- sv/bptc_coef.sv -----
// ----------------------------------------------------------------------------
// bptc_coef
// Temperature result and pressure coefficients b3, b4 and b7.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_coef (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire bptc_pkg::cal_t      cal,
    input  wire logic                in_valid,
    input  wire logic [26:0]         in_quo,
    input  wire bptc_pkg::tdiv_tag_t in_tag,
    output logic                     out_valid,
    output logic [31:0]              out_num,
    output logic [16:0]              out_den,
    output bptc_pkg::pdiv_tag_t      out_tag
);
    import bptc_pkg::*;

    logic [6:0] vld_reg;

    // Stage 1: b5 and b6.
    logic signed [27:0] x2;
    logic signed [28:0] b5;
    logic signed [28:0] c1_b5_reg;
    logic signed [29:0] c1_b6_reg;
    logic [23:0]        c1_up_reg;
    logic               c1_zero_reg;

    // Stage 2: products of b6 and the temperature result.
    logic signed [29:0] t30;
    logic signed [25:0] tt;
    logic [15:0]        temp_sat;
    logic signed [59:0] c2_sqp_reg;
    logic signed [45:0] c2_ac2p_reg;
    logic signed [45:0] c2_ac3p_reg;
    logic [23:0]        c2_up_reg;
    logic               c2_zero_reg;
    logic [15:0]        c2_temp_reg;

    // Stage 3: products of the square term.
    logic [47:0]        sq;
    logic signed [64:0] c3_b2p_reg;
    logic signed [64:0] c3_b1p_reg;
    logic signed [45:0] c3_ac2p_reg;
    logic signed [45:0] c3_ac3p_reg;
    logic [23:0]        c3_up_reg;
    logic               c3_zero_reg;
    logic [15:0]        c3_temp_reg;

    // Stage 4: x3 sums for b3 and b4.
    logic signed [54:0] x3;
    logic signed [49:0] ysum;
    logic signed [54:0] c4_x3_reg;
    logic [33:0]        c4_y_reg;
    logic [23:0]        c4_up_reg;
    logic               c4_zero_reg;
    logic [15:0]        c4_temp_reg;

    // Stage 5: b3 and the b4 multiplicand.
    logic signed [55:0] v0;
    logic signed [59:0] v;
    logic [31:0]        b3lo;
    logic [31:0]        c5_b3_reg;
    logic [31:0]        c5_u_reg;
    logic [23:0]        c5_up_reg;
    logic               c5_zero_reg;
    logic [15:0]        c5_temp_reg;

    // Stage 6: b4 and up - b3.
    logic [47:0]        b4p;
    logic [16:0]        c6_b4_reg;
    logic [31:0]        c6_dp_reg;
    logic               c6_zero_reg;
    logic [15:0]        c6_temp_reg;

    // Stage 7: b7 and divider operands.
    logic [15:0]        scale;
    logic [47:0]        b7p;
    logic [31:0]        b7;
    logic [31:0]        c7_num_reg;
    logic [16:0]        c7_den_reg;
    pdiv_tag_t          c7_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_comb begin
        x2 = in_tag.qneg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
        b5 = 29'($signed(in_tag.x1)) + 29'(x2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_b5_reg   <= b5;
            c1_b6_reg   <= 30'(b5) - $signed({18'b0, B6_OFFSET});
            c1_up_reg   <= in_tag.up;
            c1_zero_reg <= in_tag.zero;
        end
    end

    always_comb begin
        t30 = 30'(c1_b5_reg) + 30'sd8;
        tt  = t30[29:4];
        if (!tt[25] && (tt[24:15] != '0)) begin
            temp_sat = 16'h7FFF;
        end else if (tt[25] && (tt[24:15] != '1)) begin
            temp_sat = 16'h8000;
        end else begin
            temp_sat = tt[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_sqp_reg  <= 60'(c1_b6_reg) * 60'(c1_b6_reg);
            c2_ac2p_reg <= 46'($signed(cal.ac2)) * 46'(c1_b6_reg);
            c2_ac3p_reg <= 46'($signed(cal.ac3)) * 46'(c1_b6_reg);
            c2_up_reg   <= c1_up_reg;
            c2_zero_reg <= c1_zero_reg;
            c2_temp_reg <= temp_sat;
        end
    end

    assign sq = c2_sqp_reg[59:12];

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_b2p_reg  <= 65'($signed(cal.b2)) * $signed({17'b0, sq});
            c3_b1p_reg  <= 65'($signed(cal.b1)) * $signed({17'b0, sq});
            c3_ac2p_reg <= c2_ac2p_reg;
            c3_ac3p_reg <= c2_ac3p_reg;
            c3_up_reg   <= c2_up_reg;
            c3_zero_reg <= c2_zero_reg;
            c3_temp_reg <= c2_temp_reg;
        end
    end

    always_comb begin
        x3   = 55'($signed(c3_b2p_reg[64:11])) + 55'($signed(c3_ac2p_reg[45:11]));
        ysum = 50'($signed(c3_ac3p_reg[45:13])) + 50'($signed(c3_b1p_reg[64:16]))
             + 50'sd2;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c4_x3_reg   <= x3;
            c4_y_reg    <= ysum[33:0];
            c4_up_reg   <= c3_up_reg;
            c4_zero_reg <= c3_zero_reg;
            c4_temp_reg <= c3_temp_reg;
        end
    end

    // b3 = ((4*ac1 + x3) << oss + 2) / 4 with truncation toward zero.
    always_comb begin
        v0   = 56'($signed({cal.ac1, 2'b00})) + 56'(c4_x3_reg);
        v    = (60'(v0) <<< cal.oss) + 60'sd2;
        b3lo = v[33:2] + {31'b0, v[59] && (v[1:0] != 2'b00)};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c5_b3_reg   <= b3lo;
            c5_u_reg    <= c4_y_reg[33:2] + HALF_OFFSET;
            c5_up_reg   <= c4_up_reg;
            c5_zero_reg <= c4_zero_reg;
            c5_temp_reg <= c4_temp_reg;
        end
    end

    assign b4p = {32'b0, cal.ac4} * {16'b0, c5_u_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            c6_b4_reg   <= b4p[31:15];
            c6_dp_reg   <= {8'b0, c5_up_reg} - c5_b3_reg;
            c6_zero_reg <= c5_zero_reg;
            c6_temp_reg <= c5_temp_reg;
        end
    end

    always_comb begin
        scale = B7_SCALE >> cal.oss;
        b7p   = {16'b0, c6_dp_reg} * {32'b0, scale};
        b7    = b7p[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c7_num_reg      <= b7[31] ? b7 : {b7[30:0], 1'b0};
            c7_den_reg      <= c6_b4_reg;
            c7_tag_reg.temp <= c6_temp_reg;
            c7_tag_reg.err  <= c6_zero_reg || (c6_b4_reg == '0);
            c7_tag_reg.hi   <= b7[31];
        end
    end

    assign out_valid = vld_reg[6];
    assign out_num   = c7_num_reg;
    assign out_den   = c7_den_reg;
    assign out_tag   = c7_tag_reg;

endmodule

`default_nettype wire

// ----- sv/bptc_post.sv -----
// ----------------------------------------------------------------------------
// bptc_post
// Pressure polynomial correction, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_post (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [31:0]         in_quo,
    input  wire bptc_pkg::pdiv_tag_t in_tag,
    output logic                     out_valid,
    output logic [15:0]              temperature,
    output logic [17:0]              pressure,
    output logic                     divide_error
);
    import bptc_pkg::*;

    logic [3:0]  vld_reg;

    logic [31:0] q;
    logic [31:0] p1_q_reg;
    logic [47:0] p1_sqq_reg;
    logic [44:0] p1_x2m_reg;
    pdiv_tag_t   p1_tag_reg;

    logic [31:0] p2_q_reg;
    logic [59:0] p2_x1c_reg;
    logic [44:0] p2_x2m_reg;
    pdiv_tag_t   p2_tag_reg;

    logic signed [45:0] neg;
    logic signed [45:0] s;
    logic [31:0]        p3_q_reg;
    logic signed [45:0] p3_s_reg;
    pdiv_tag_t          p3_tag_reg;

    logic signed [46:0] pf;
    logic [17:0]        p_sat;
    logic [15:0]        temp_reg;
    logic [17:0]        press_reg;
    logic               err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // The quotient was taken from b7 or 2*b7; restore the doubling where needed.
    assign q = in_tag.hi ? {in_quo[30:0], 1'b0} : in_quo;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_q_reg   <= q;
            p1_sqq_reg <= {24'b0, q[31:8]} * {24'b0, q[31:8]};
            p1_x2m_reg <= {13'b0, q} * {32'b0, P_LIN_COEF};
            p1_tag_reg <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_q_reg   <= p1_q_reg;
            p2_x1c_reg <= {12'b0, p1_sqq_reg} * {48'b0, P_SQ_COEF};
            p2_x2m_reg <= p1_x2m_reg;
            p2_tag_reg <= p1_tag_reg;
        end
    end

    always_comb begin
        neg = -$signed({1'b0, p2_x2m_reg});
        s   = $signed({2'b0, p2_x1c_reg[59:16]}) + 46'($signed(neg[45:16]))
            + $signed({34'b0, P_OFFSET});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_q_reg   <= p2_q_reg;
            p3_s_reg   <= s;
            p3_tag_reg <= p2_tag_reg;
        end
    end

    always_comb begin
        pf = $signed({15'b0, p3_q_reg}) + 47'($signed(p3_s_reg[45:4]));
        if (pf[46]) begin
            p_sat = '0;
        end else if (pf[45:18] != '0) begin
            p_sat = P_MAX;
        end else begin
            p_sat = pf[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg  <= p3_tag_reg.err ? '0 : p3_tag_reg.temp;
            press_reg <= p3_tag_reg.err ? '0 : p_sat;
            err_reg   <= p3_tag_reg.err;
        end
    end

    assign out_valid    = vld_reg[3];
    assign temperature  = temp_reg;
    assign pressure     = press_reg;
    assign divide_error = err_reg;

endmodule

`default_nettype wire

// ----- sv/baro_temp_press_compensation_top.sv -----
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Turns raw sensor words into temperature (0.1 degC) and pressure (Pa).
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel carries one raw temperature word and
// one raw 24-bit pressure word; each produces exactly one request on the m_
// channel with the compensated temperature and pressure, in input order.
// m_tuser flags a zero divisor, in which case both result fields are zero.
// Calibration and oversampling are written through cfg_wr_en/cfg_index/
// cfg_wdata; the user must do so only while no request is in flight, which
// the block does not enforce. They reset to zero. The path holds 3 front
// stages, a 27-stage temperature divider, 7 coefficient stages, a 32-stage
// pressure divider and 4 correction stages. One request is accepted every
// cycle while not stalled; the fully pipelined bit-per-stage dividers set
// the rate. The whole pipeline advances together: when m_tvalid is high and
// m_tready low, every stage holds and s_tready drops, so nothing is lost or
// repeated. A synchronous low aresetn clears valid bits and config registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "baro_temp_press_compensation_top_defines.svh"

module baro_temp_press_compensation_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input requests.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [15:0] raw_temperature, [39:16] raw_pressure_word
    // Result requests.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] temperature, [33:16] pressure, rest zero
    output logic [0:0]       m_tuser,   // [0] divide_error
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import bptc_pkg::*;

    cal_t cal;
    logic en;

    // Front stage 1: offset temperature and oversampling shift.
    logic [3:0]         shamt;
    logic               f1_vld_reg;
    logic signed [16:0] f1_diff_reg;
    logic [23:0]        f1_up_reg;

    // Front stage 2: x1 product.
    logic               f2_vld_reg;
    logic signed [33:0] f2_prod_reg;
    logic [23:0]        f2_up_reg;

    // Front stage 3: divider operands as magnitudes with a sign.
    logic signed [18:0] x1;
    logic signed [19:0] den;
    logic signed [26:0] num;
    logic               f3_vld_reg;
    logic [26:0]        f3_num_reg;
    logic [19:0]        f3_den_reg;
    tdiv_tag_t          f3_tag_reg;

    logic               td_valid;
    logic [26:0]        td_quo;
    logic [$bits(tdiv_tag_t)-1:0] td_tag;

    logic               cf_valid;
    logic [31:0]        cf_num;
    logic [16:0]        cf_den;
    pdiv_tag_t          cf_tag;

    logic               pd_valid;
    logic [31:0]        pd_quo;
    logic [$bits(pdiv_tag_t)-1:0] pd_tag;

    logic [15:0]        temperature;
    logic [17:0]        pressure;
    logic               divide_error;

    // The pipeline moves whenever the output register is free or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    bptc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cal       (cal)
    );

    assign shamt = 4'd8 - {2'b00, cal.oss};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= s_tvalid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_diff_reg <= $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, cal.ac6});
            f1_up_reg   <= s_tdata[39:16] >> shamt;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_prod_reg <= 34'(f1_diff_reg) * 34'($signed({1'b0, cal.ac5}));
            f2_up_reg   <= f1_up_reg;
        end
    end

    // x1 = (ut - ac6) * ac5 >> 15; the divisor is x1 + md, the dividend mc * 2048.
    always_comb begin
        x1  = f2_prod_reg[33:15];
        den = 20'(x1) + 20'($signed(cal.md));
        num = $signed({cal.mc, 11'b0});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_num_reg      <= num[26] ? 27'(-num) : 27'(num);
            f3_den_reg      <= den[19] ? 20'(-den) : 20'(den);
            f3_tag_reg.x1   <= x1;
            f3_tag_reg.up   <= f2_up_reg;
            f3_tag_reg.qneg <= num[26] ^ den[19];
            f3_tag_reg.zero <= (den == '0);
        end
    end

    bptc_div #(
        .DW (TDIV_DW),
        .VW (TDIV_VW),
        .TW ($bits(tdiv_tag_t))
    ) u_tdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f3_vld_reg),
        .in_num    (f3_num_reg),
        .in_den    (f3_den_reg),
        .in_tag    (f3_tag_reg),
        .out_valid (td_valid),
        .out_quo   (td_quo),
        .out_tag   (td_tag)
    );

    bptc_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cal       (cal),
        .in_valid  (td_valid),
        .in_quo    (td_quo),
        .in_tag    (tdiv_tag_t'(td_tag)),
        .out_valid (cf_valid),
        .out_num   (cf_num),
        .out_den   (cf_den),
        .out_tag   (cf_tag)
    );

    bptc_div #(
        .DW (PDIV_DW),
        .VW (PDIV_VW),
        .TW ($bits(pdiv_tag_t))
    ) u_pdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cf_valid),
        .in_num    (cf_num),
        .in_den    (cf_den),
        .in_tag    (cf_tag),
        .out_valid (pd_valid),
        .out_quo   (pd_quo),
        .out_tag   (pd_tag)
    );

    bptc_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (pd_valid),
        .in_quo       (pd_quo),
        .in_tag       (pdiv_tag_t'(pd_tag)),
        .out_valid    (m_tvalid),
        .temperature  (temperature),
        .pressure     (pressure),
        .divide_error (divide_error)
    );

    assign m_tdata = {6'b0, pressure, temperature};
    assign m_tuser = divide_error;

    // A flagged divide error always comes with zeroed result fields.
    `BPTC_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0, "divide error with nonzero data")
    // No new request is taken while a result is stalled at the output.
    `BPTC_ASSERT_IMPL(a_stall_block, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken during output stall")
    // Reset empties the output register.
    `BPTC_ASSERT_NEXT(a_rst_clear, aclk, 1'b1, !aresetn, !m_tvalid, "output valid after reset")

endmodule

`default_nettype wire
